@@ hw/rtl/rhht_pkg.sv @@
// Shared types and constants for the Robin Hood hash table.
// No dependencies.
package rhht_pkg;
  localparam int DefSlotCount = 256;
  localparam int DefValueBits = 64;
  localparam int HashBits     = 48;
  localparam int CountBits    = 9;
  localparam int IdxBits      = 8;
  localparam int StatusBits   = 3;
  localparam logic [CountBits-1:0] MaxEntriesReset = 9'd153;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_PROBE  = 2'd3
  } op_t;

  typedef enum logic [StatusBits-1:0] {
    ST_NEW     = 3'd0,
    ST_REPLACE = 3'd1,
    ST_HIT     = 3'd2,
    ST_MISS    = 3'd3,
    ST_FULL    = 3'd4
  } status_t;
endpackage

@@ hw/rtl/rhht_if.sv @@
// Valid/ready channel interfaces for the hash table.
// Depends on rhht_pkg.
interface rhht_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [rhht_pkg::HashBits-1:0] key_hash;
  logic [63:0]                   new_value;
  logic [rhht_pkg::IdxBits-1:0]  slot_index;
  modport source (output valid, operation, key_hash, new_value, slot_index, input ready);
  modport sink   (input valid, operation, key_hash, new_value, slot_index, output ready);
endinterface

interface rhht_out_if;
  logic                            valid;
  logic                            ready;
  logic [rhht_pkg::StatusBits-1:0] status;
  logic [63:0]                     result_value;
  logic [rhht_pkg::CountBits-1:0]  entry_total;
  modport source (output valid, status, result_value, entry_total, input ready);
  modport sink   (input valid, status, result_value, entry_total, output ready);
endinterface

interface rhht_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rhht_pkg::CountBits-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hw/rtl/robin_hood_hash_table.sv @@
// Robin Hood hash table: one word in, one word out, a new word taken only when idle.
// Each operation walks the slot memory one slot at a time: a read state, then a compare
// or write state for each slot visited. After reset a clearing pass zeroes every slot of
// the distance memory before the first word is taken. Depends on rhht_pkg and rhht_if.
module robin_hood_hash_table #(
  parameter int VALUE_BITS = rhht_pkg::DefValueBits
) (
  input  logic       clk,
  input  logic       rst_n,
  rhht_in_if.sink    in_ch,
  rhht_out_if.source out_ch,
  rhht_cfg_if.sink   cfg_ch
);
  import rhht_pkg::*;

  localparam int SLOT_COUNT = DefSlotCount;
  localparam int AW = $clog2(SLOT_COUNT);
  localparam int DW = AW + 2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FRD, S_FCMP, S_IRD, S_ICMP, S_DRD, S_DCMP, S_PRD, S_PCMP, S_OUT
  } state_t;

  state_t                 state_r;
  logic [AW:0]            clr_r;
  logic [CountBits-1:0]   max_r, count_r;
  logic [1:0]             op_r;
  logic [HashBits-1:0]    ck_r;
  logic [VALUE_BITS-1:0]  cv_r, nv_r;
  logic [DW-1:0]          cd_r;
  logic [AW-1:0]          pos_r, prev_r;
  logic [AW:0]            n_r;
  logic [StatusBits-1:0]  st_r;
  logic [63:0]            rv_r;

  logic [HashBits-1:0]    mkey [SLOT_COUNT];
  logic [VALUE_BITS-1:0]  mdat [SLOT_COUNT];
  logic [DW-1:0]          mdst [SLOT_COUNT];
  logic [HashBits-1:0]    rk_r;
  logic [VALUE_BITS-1:0]  rdv_r;
  logic [DW-1:0]          rd_r;

  logic                   re, we, wkd;
  logic [AW-1:0]          ra, wa;
  logic [HashBits-1:0]    wk;
  logic [VALUE_BITS-1:0]  wv;
  logic [DW-1:0]          wd;
  logic [AW-1:0]          pos_nxt;
  logic [CountBits-1:0]   lim;

  assign pos_nxt = (pos_r == AW'(SLOT_COUNT - 1)) ? '0 : pos_r + 1'b1;
  assign lim = (max_r > CountBits'(SLOT_COUNT)) ? CountBits'(SLOT_COUNT) : max_r;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.status = st_r;
  assign out_ch.result_value = rv_r;
  assign out_ch.entry_total = count_r;

  always_comb begin
    re = 1'b0; ra = pos_r;
    we = 1'b0; wkd = 1'b1; wa = pos_r; wk = ck_r; wv = cv_r; wd = cd_r;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1; wkd = 1'b0; wa = clr_r[AW-1:0]; wd = '0;
      end
      S_FRD, S_IRD, S_DRD, S_PRD: re = 1'b1;
      S_FCMP: begin
        if (rd_r != '0 && rk_r == ck_r && op_r == OP_INSERT) begin
          we = 1'b1; wkd = 1'b0; wv = nv_r; wd = rd_r;
        end
      end
      S_ICMP: begin
        if (rd_r == '0 || rd_r < cd_r) we = 1'b1;
      end
      S_DCMP: begin
        we = 1'b1; wa = prev_r;
        if (rd_r <= DW'(1) || n_r == (AW+1)'(SLOT_COUNT)) begin
          wkd = 1'b0; wd = '0;
        end else begin
          wk = rk_r; wv = rdv_r; wd = rd_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rk_r <= mkey[ra]; rdv_r <= mdat[ra]; rd_r <= mdst[ra];
    end
    if (we) begin
      mdst[wa] <= wd;
      if (wkd) mkey[wa] <= wk;
      if (wkd || state_r == S_FCMP) mdat[wa] <= wv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; max_r <= MaxEntriesReset; count_r <= '0;
    end else begin
      if (cfg_ch.valid) max_r <= cfg_ch.data;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (AW+1)'(SLOT_COUNT - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          op_r  <= in_ch.operation;
          ck_r  <= in_ch.key_hash;
          nv_r  <= in_ch.new_value[VALUE_BITS-1:0];
          cv_r  <= in_ch.new_value[VALUE_BITS-1:0];
          cd_r  <= DW'(1);
          n_r   <= '0;
          rv_r  <= '0;
          st_r  <= ST_MISS;
          if (in_ch.operation == OP_PROBE) begin
            pos_r <= in_ch.slot_index;
            state_r <= S_PRD;
          end else begin
            pos_r <= in_ch.key_hash[AW-1:0];
            state_r <= S_FRD;
          end
        end
        S_FRD: state_r <= S_FCMP;
        S_FCMP: begin
          if (rd_r == '0 || n_r == (AW+1)'(SLOT_COUNT)) begin
            if (op_r != OP_INSERT) state_r <= S_OUT;
            else if (count_r >= lim) begin st_r <= ST_FULL; state_r <= S_OUT; end
            else begin pos_r <= ck_r[AW-1:0]; state_r <= S_IRD; end
          end else if (rk_r == ck_r) begin
            rv_r <= 64'(rdv_r);
            if (op_r == OP_INSERT) begin st_r <= ST_REPLACE; state_r <= S_OUT; end
            else if (op_r == OP_LOOKUP) begin st_r <= ST_HIT; state_r <= S_OUT; end
            else begin
              st_r <= ST_HIT; prev_r <= pos_r; pos_r <= pos_nxt; n_r <= '0;
              state_r <= S_DRD;
            end
          end else begin
            pos_r <= pos_nxt; n_r <= n_r + 1'b1; state_r <= S_FRD;
          end
        end
        S_IRD: state_r <= S_ICMP;
        S_ICMP: begin
          if (rd_r == '0) begin
            count_r <= count_r + 1'b1; st_r <= ST_NEW; state_r <= S_OUT;
          end else begin
            if (rd_r < cd_r) begin
              ck_r <= rk_r; cv_r <= rdv_r; cd_r <= rd_r + 1'b1;
            end else cd_r <= cd_r + 1'b1;
            pos_r <= pos_nxt; state_r <= S_IRD;
          end
        end
        S_DRD: state_r <= S_DCMP;
        S_DCMP: begin
          if (rd_r <= DW'(1) || n_r == (AW+1)'(SLOT_COUNT)) begin
            count_r <= count_r - 1'b1; state_r <= S_OUT;
          end else begin
            prev_r <= pos_r; pos_r <= pos_nxt; n_r <= n_r + 1'b1; state_r <= S_DRD;
          end
        end
        S_PRD: state_r <= S_PCMP;
        S_PCMP: begin
          if (rd_r != '0) begin st_r <= ST_HIT; rv_r <= 64'(rdv_r); end
          state_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ tb/robin_hood_hash_table_tb.sv @@
// Testbench for the Robin Hood hash table: drives insert, lookup, delete and probe
// words, predicts each result with its own copy of the slot table, checks every word.
// Depends on rhht_pkg, rhht_if and robin_hood_hash_table.
module robin_hood_hash_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rhht_pkg::*;

  localparam int Slots = DefSlotCount;
  localparam longint unsigned CycleLimit = 5000000;

  typedef struct {
    status_t                     status;
    logic [63:0]                 value;
    logic [CountBits-1:0]        total;
  } table_result_t;

  class table_scoreboard;
    logic [HashBits-1:0] keys [Slots];
    int unsigned         slot_dst [Slots];
    logic [63:0]         data [Slots];
    int unsigned         count;
    int unsigned         limit;
    table_result_t       pending [$];
    int                  mismatches;
    int                  results_seen;

    function new();
      foreach (slot_dst[i]) begin
        slot_dst[i] = 0;
        keys[i] = '0;
        data[i] = '0;
      end
      count = 0;
      limit = 32'(MaxEntriesReset);
      mismatches = 0;
      results_seen = 0;
    endfunction

    function bit locate(logic [HashBits-1:0] h, output int unsigned pos);
      int unsigned i;
      i = 32'(h % Slots);
      pos = 0;
      for (int n = 0; n < Slots; n++) begin
        if (slot_dst[i] == 0) return 0;
        if (keys[i] == h) begin
          pos = i;
          return 1;
        end
        i = (i + 1) % Slots;
      end
      return 0;
    endfunction

    function void note_word(op_t op, logic [HashBits-1:0] h, logic [63:0] v,
                            logic [IdxBits-1:0] idx);
      table_result_t r;
      int unsigned pos, i, cd, td, prev, nx;
      logic [HashBits-1:0] ck, tk;
      logic [63:0] cv, tv;
      r.status = ST_MISS;
      r.value = '0;
      case (op)
        OP_INSERT: begin
          if (locate(h, pos)) begin
            r.value = data[pos];
            data[pos] = v;
            r.status = ST_REPLACE;
          end else if (count >= limit || count >= Slots) begin
            r.status = ST_FULL;
          end else begin
            ck = h; cv = v; cd = 1; i = 32'(h % Slots);
            for (int n = 0; n <= Slots; n++) begin
              if (slot_dst[i] == 0) begin
                keys[i] = ck; data[i] = cv; slot_dst[i] = cd;
                count++;
                break;
              end
              if (slot_dst[i] < cd) begin
                tk = keys[i]; tv = data[i]; td = slot_dst[i];
                keys[i] = ck; data[i] = cv; slot_dst[i] = cd;
                ck = tk; cv = tv; cd = td;
              end
              i = (i + 1) % Slots;
              cd++;
            end
            r.status = ST_NEW;
          end
        end
        OP_LOOKUP: begin
          if (locate(h, pos)) begin
            r.value = data[pos];
            r.status = ST_HIT;
          end
        end
        OP_DELETE: begin
          if (locate(h, pos)) begin
            r.value = data[pos];
            prev = pos;
            for (int n = 0; n < Slots; n++) begin
              nx = (prev + 1) % Slots;
              if (slot_dst[nx] <= 1) break;
              keys[prev] = keys[nx];
              data[prev] = data[nx];
              slot_dst[prev] = slot_dst[nx] - 1;
              prev = nx;
            end
            slot_dst[prev] = 0;
            count--;
            r.status = ST_HIT;
          end
        end
        default: begin
          if (slot_dst[idx % Slots] != 0) begin
            r.value = data[idx % Slots];
            r.status = ST_HIT;
          end
        end
      endcase
      r.total = count[CountBits-1:0];
      pending.push_back(r);
    endfunction

    function void check_word(logic [StatusBits-1:0] st, logic [63:0] v,
                             logic [CountBits-1:0] tot);
      table_result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: st=%0d val=%h", st, v);
        return;
      end
      e = pending.pop_front();
      if (st !== e.status || v !== e.value || tot !== e.total) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d val=%h tot=%0d, got st=%0d val=%h tot=%0d",
                   e.status, e.value, e.total, st, v, tot);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rhht_in_if  in_ch();
  rhht_out_if out_ch();
  rhht_cfg_if cfg_ch();

  robin_hood_hash_table u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  table_scoreboard sb = new();
  logic [HashBits-1:0] used_keys [$];
  longint unsigned cycles = 0;
  bit stall_long = 0;
  int words_sent = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.key_hash = '0;
    in_ch.new_value = '0;
    in_ch.slot_index = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // valid stays high on return; idle_gap (when its gap is nonzero) or drain drops it
  task automatic send_word(op_t op, logic [HashBits-1:0] h, logic [63:0] v,
                           logic [IdxBits-1:0] idx);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.key_hash <= h;
    in_ch.new_value <= v;
    in_ch.slot_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(op, h, v, idx);
    if (op == OP_INSERT) used_keys.push_back(h);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int g;
    g = pick_gap();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
  endtask

  task automatic set_limit(int unsigned lim);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= lim[CountBits-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    sb.limit = lim;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [HashBits-1:0] pick_key(int unsigned home_span);
    logic [HashBits-1:0] h;
    if (used_keys.size() != 0 && $urandom_range(0, 1))
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    h = HashBits'({$urandom, $urandom});
    h[7:0] = 8'($urandom_range(0, home_span));
    return h;
  endfunction

  task automatic random_phase(int n, int unsigned span);
    int unsigned r;
    op_t op;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      op = r < 4 ? OP_INSERT : r < 6 ? OP_LOOKUP : r < 8 ? OP_DELETE : OP_PROBE;
      send_word(op, pick_key(span), {$urandom, $urandom}, IdxBits'($urandom));
      idle_gap();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed
    send_word(OP_PROBE, '0, '0, 8'd0);
    send_word(OP_LOOKUP, 48'h0, '0, '0);
    send_word(OP_DELETE, 48'hFFFF_FFFF_FFFF, '0, '0);
    send_word(OP_INSERT, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
    send_word(OP_INSERT, 48'hFFFF_FFFF_FFFF, 64'h0, '0);
    send_word(OP_INSERT, 48'h1_0000_0000, 64'h1234, '0);
    send_word(OP_INSERT, 48'h2_0000_0000, 64'h5678, '0);
    send_word(OP_INSERT, 48'h0000_0000_0001, 64'h9, '0);
    send_word(OP_INSERT, 48'h0, 64'hA5A5, '0);
    send_word(OP_LOOKUP, 48'h2_0000_0000, '0, '0);
    send_word(OP_PROBE, '0, '0, 8'd255);
    send_word(OP_PROBE, '0, '0, 8'd1);
    send_word(OP_PROBE, '0, '0, 8'd2);
    send_word(OP_DELETE, 48'h0, '0, '0);
    send_word(OP_LOOKUP, 48'h1_0000_0000, '0, '0);
    send_word(OP_PROBE, '0, '0, 8'd0);
    set_limit(0);
    send_word(OP_INSERT, 48'h3_0000_0000, 64'h1, '0);
    send_word(OP_INSERT, 48'h2_0000_0000, 64'h2, '0);
    set_limit(300);
    // fill completely, then search a full table
    for (int k = 0; k < Slots; k++)
      send_word(OP_INSERT, HashBits'({$urandom, $urandom}), {$urandom, $urandom}, '0);
    send_word(OP_INSERT, 48'h7777_7777_7777, 64'h3, '0);
    send_word(OP_LOOKUP, 48'h7777_7777_7777, '0, '0);
    send_word(OP_DELETE, 48'h7777_7777_7777, '0, '0);
    for (int k = 0; k < 60; k++)
      send_word(OP_DELETE, used_keys[used_keys.size() - 1 - k], '0, '0);
    set_limit(256);
    // receiver holds off while words keep coming
    stall_long = 1;
    random_phase(30, 255);
    stall_long = 0;
    drain();
    set_limit(20);
    random_phase(20, 31);
    set_limit(32'(MaxEntriesReset));
    random_phase(20, 63);
    drain();
    $display("sent %0d words over insert/lookup/delete/probe, limits 0..300, full table",
             words_sent);
    $display("checked %0d result words", sb.results_seen);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (stall_long) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end else begin
        g = pick_gap();
        if (g != 0) begin
          out_ch.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.status, out_ch.result_value, out_ch.entry_total);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end
endmodule
